### src/smg_pkg.sv
`timescale 1ns / 1ps
package smg_pkg;

   localparam int MAX_B   = 32;
   localparam int COORD_W = 16;
   localparam int HGT_W   = 16;
   localparam int IDX_W   = $clog2(MAX_B);
   localparam int CNT_W   = $clog2(MAX_B + 1);
   localparam int PA_W    = IDX_W + 1;
   localparam int PT_W    = IDX_W + 2;
   localparam int PTS     = 2 * MAX_B;
   localparam int STK_D   = IDX_W;
   localparam int STK_AW  = $clog2(STK_D);
   localparam int SP_W    = $clog2(STK_D + 1);
   localparam int BLD_W   = 2 * COORD_W + HGT_W;
   localparam int PNT_W   = COORD_W + HGT_W;

   typedef enum logic [1:0] {
      PH_LEFT,
      PH_RIGHT,
      PH_MERGE
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_STORE,
      CMD_LEAF0,
      CMD_LEAF1,
      CMD_CLEAR,
      CMD_MEXEC,
      CMD_OLOAD
   } op_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_EVAL,
      S_LRD,
      S_LW0,
      S_LW1,
      S_RET,
      S_MINIT,
      S_MRD,
      S_MEX,
      S_OINIT,
      S_ORD,
      S_OLOAD,
      S_OWAIT
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      phase_type        ph;
      logic [PT_W-1:0]  na;
   } frame_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] st_addr;
      logic             rd_par;
      logic             wr_par;
      logic [PA_W-1:0]  base_a;
      logic [PA_W-1:0]  base_b;
      logic [PA_W-1:0]  base_w;
      logic [PT_W-1:0]  na;
      logic [PT_W-1:0]  nb;
   } cmd_type;

   typedef struct packed {
      logic            a_left;
      logic            b_left;
      logic [PT_W-1:0] k;
      logic            out_last;
   } status_type;

endpackage

### src/smg_if.sv
`timescale 1ns / 1ps
interface smg_req_if import smg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] left_edge;
   logic [COORD_W-1:0] right_edge;
   logic [HGT_W-1:0]   height;
   logic               last_building;

   modport source (output valid, output left_edge, output right_edge, output height,
                   output last_building, input ready);
   modport sink (input valid, input left_edge, input right_edge, input height,
                 input last_building, output ready);
endinterface

interface smg_rsp_if import smg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] point_x;
   logic [HGT_W-1:0]   point_height;
   logic               last_point;

   modport source (output valid, output point_x, output point_height, output last_point,
                   input ready);
   modport sink (input valid, input point_x, input point_height, input last_point,
                 output ready);
endinterface

### src/smg_ram.sv
`timescale 1ns / 1ps
module smg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_a_ff <= mem_ff[raddr_a];
      rd_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;
endmodule

### src/smg_datapath.sv
`timescale 1ns / 1ps
module smg_datapath import smg_pkg::*; (
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic [COORD_W-1:0] in_left,
   input  logic [COORD_W-1:0] in_right,
   input  logic [HGT_W-1:0]   in_height,
   output status_type         st,
   output logic [COORD_W-1:0] out_x,
   output logic [HGT_W-1:0]   out_h,
   output logic               out_last
);
   logic [PT_W-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [HGT_W-1:0]   hl_ff, hl_in, hr_ff, hr_in, cur_ff, cur_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [HGT_W-1:0]   h_ff, h_in;
   logic               last_ff, last_in;

   logic [BLD_W-1:0]   st_rdata;
   logic [PNT_W-1:0]   b0_a, b0_b, b1_a, b1_b, pa, pb, wr_data;
   logic [PA_W-1:0]    raddr_a, raddr_b, wr_addr;
   logic [PT_W-1:0]    wr_off;
   logic               buf_we, a_left, b_left;

   smg_ram #(.WIDTH(BLD_W), .DEPTH(MAX_B)) u_store (
      .clock(clock), .we(cmd.op == CMD_STORE), .waddr(cmd.st_addr),
      .wdata({in_left, in_right, in_height}), .raddr_a(cmd.st_addr),
      .raddr_b(cmd.st_addr), .rdata_a(st_rdata), .rdata_b()
   );

   smg_ram #(.WIDTH(PNT_W), .DEPTH(PTS)) u_buf0 (
      .clock(clock), .we(buf_we && !cmd.wr_par), .waddr(wr_addr), .wdata(wr_data),
      .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(b0_a), .rdata_b(b0_b)
   );

   smg_ram #(.WIDTH(PNT_W), .DEPTH(PTS)) u_buf1 (
      .clock(clock), .we(buf_we && cmd.wr_par), .waddr(wr_addr), .wdata(wr_data),
      .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(b1_a), .rdata_b(b1_b)
   );

   assign raddr_a = cmd.base_a + i_ff[PA_W-1:0];
   assign raddr_b = cmd.base_b + j_ff[PA_W-1:0];
   assign wr_addr = cmd.base_w + wr_off[PA_W-1:0];
   assign pa      = cmd.rd_par ? b1_a : b0_a;
   assign pb      = cmd.rd_par ? b1_b : b0_b;
   assign a_left  = i_ff < cmd.na;
   assign b_left  = j_ff < cmd.nb;

   always_comb begin
      logic [COORD_W-1:0] ax, bx, ex;
      logic [HGT_W-1:0]   mh;
      ax      = pa[PNT_W-1:HGT_W];
      bx      = pb[PNT_W-1:HGT_W];
      ex      = ax;
      mh      = '0;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      hl_in   = hl_ff;
      hr_in   = hr_ff;
      cur_in  = cur_ff;
      x_in    = x_ff;
      h_in    = h_ff;
      last_in = last_ff;
      buf_we  = 1'b0;
      wr_data = pa;
      wr_off  = k_ff;
      unique case (cmd.op)
         CMD_CLEAR: begin
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            hl_in  = '0;
            hr_in  = '0;
            cur_in = '0;
         end
         CMD_LEAF0: begin
            buf_we  = 1'b1;
            wr_off  = '0;
            wr_data = {st_rdata[BLD_W-1:COORD_W+HGT_W], st_rdata[HGT_W-1:0]};
         end
         CMD_LEAF1: begin
            buf_we  = 1'b1;
            wr_off  = PT_W'(1);
            wr_data = {st_rdata[COORD_W+HGT_W-1:HGT_W], {HGT_W{1'b0}}};
            k_in    = PT_W'(2);
         end
         CMD_MEXEC: begin
            if (a_left && b_left) begin
               if (ax < bx) begin
                  hl_in = pa[HGT_W-1:0];
                  i_in  = i_ff + 1'b1;
               end else if (bx < ax) begin
                  hr_in = pb[HGT_W-1:0];
                  ex    = bx;
                  j_in  = j_ff + 1'b1;
               end else begin
                  hl_in = pa[HGT_W-1:0];
                  hr_in = pb[HGT_W-1:0];
                  i_in  = i_ff + 1'b1;
                  j_in  = j_ff + 1'b1;
               end
               mh = (hl_in > hr_in) ? hl_in : hr_in;
               if (mh != cur_ff) begin
                  buf_we  = 1'b1;
                  wr_data = {ex, mh};
                  k_in    = k_ff + 1'b1;
                  cur_in  = mh;
               end
            end else if (a_left) begin
               // tail copied as it stands
               buf_we = 1'b1;
               k_in   = k_ff + 1'b1;
               i_in   = i_ff + 1'b1;
            end else if (b_left) begin
               buf_we  = 1'b1;
               wr_data = pb;
               k_in    = k_ff + 1'b1;
               j_in    = j_ff + 1'b1;
            end
         end
         CMD_OLOAD: begin
            x_in    = ax;
            h_in    = pa[HGT_W-1:0];
            last_in = (i_ff + 1'b1) == cmd.na;
            i_in    = i_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      hl_ff   <= hl_in;
      hr_ff   <= hr_in;
      cur_ff  <= cur_in;
      x_ff    <= x_in;
      h_ff    <= h_in;
      last_ff <= last_in;
   end

   assign st.a_left   = a_left;
   assign st.b_left   = b_left;
   assign st.k        = k_ff;
   assign st.out_last = last_ff;
   assign out_x       = x_ff;
   assign out_h       = h_ff;
   assign out_last    = last_ff;
endmodule

### src/smg_ctrl.sv
`timescale 1ns / 1ps
module smg_ctrl import smg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type st,
   output cmd_type    cmd
);
   state_type        state_ff, state_in;
   frame_type        top_ff, top_in;
   frame_type        stk_ff [STK_D];
   logic [PT_W-1:0]  nb_ff, nb_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic [IDX_W:0]   sum;
   logic [IDX_W-1:0] mid, mid1;
   logic             room;
   frame_type        parent;

   assign sum    = {1'b0, top_ff.lo} + {1'b0, top_ff.hi};
   assign mid    = sum[IDX_W:1];
   assign mid1   = mid + 1'b1;
   assign room   = count_ff < CNT_W'(MAX_B);
   assign parent = stk_ff[STK_AW'(sp_ff - 1'b1)];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:  if (req_valid && req_last) state_in = S_EVAL;
         S_EVAL: begin
            if (top_ff.lo == top_ff.hi) begin
               state_in = S_LRD;
            end else if (top_ff.ph != PH_LEFT && top_ff.ph != PH_RIGHT) begin
               state_in = S_MINIT;
            end
         end
         S_LRD:   state_in = S_LW0;
         S_LW0:   state_in = S_LW1;
         S_LW1:   state_in = S_RET;
         S_RET:   state_in = (sp_ff == '0) ? S_OINIT : S_EVAL;
         S_MINIT: state_in = S_MRD;
         S_MRD:   state_in = S_MEX;
         S_MEX:   state_in = (st.a_left || st.b_left) ? S_MRD : S_RET;
         S_OINIT: state_in = S_ORD;
         S_ORD:   state_in = S_OLOAD;
         S_OLOAD: state_in = S_OWAIT;
         S_OWAIT: if (rsp_ready) state_in = st.out_last ? S_LOAD : S_ORD;
         default: state_in = S_LOAD;
      endcase
   end

   // outputs and commands
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.op      = CMD_NOP;
      cmd.st_addr = top_ff.lo;
      cmd.rd_par  = ~sp_ff[0];
      cmd.wr_par  = sp_ff[0];
      cmd.base_a  = {top_ff.lo, 1'b0};
      cmd.base_b  = {mid1, 1'b0};
      cmd.base_w  = {top_ff.lo, 1'b0};
      cmd.na      = top_ff.na;
      cmd.nb      = nb_ff;
      unique case (state_ff)
         S_LOAD: begin
            req_ready   = 1'b1;
            cmd.st_addr = count_ff[IDX_W-1:0];
            if (req_valid && room) cmd.op = CMD_STORE;
         end
         S_LW0:   cmd.op = CMD_LEAF0;
         S_LW1:   cmd.op = CMD_LEAF1;
         S_MINIT: cmd.op = CMD_CLEAR;
         S_MEX:   if (st.a_left || st.b_left) cmd.op = CMD_MEXEC;
         S_OINIT, S_ORD, S_OLOAD, S_OWAIT: begin
            // final skyline sits in buffer 0 from point 0
            cmd.rd_par = 1'b0;
            cmd.base_a = '0;
            if (state_ff == S_OINIT) cmd.op = CMD_CLEAR;
            if (state_ff == S_OLOAD) cmd.op = CMD_OLOAD;
            rsp_valid = (state_ff == S_OWAIT);
         end
         default: begin
         end
      endcase
   end

   // traversal stack and building count
   always_comb begin
      top_in   = top_ff;
      nb_in    = nb_ff;
      sp_in    = sp_ff;
      count_in = count_ff;
      push     = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (room) count_in = count_ff + 1'b1;
               if (req_last) begin
                  top_in.lo = '0;
                  top_in.hi = IDX_W'(count_in - 1'b1);
                  top_in.ph = PH_LEFT;
                  sp_in     = '0;
                  count_in  = '0;
               end
            end
         end
         S_EVAL: begin
            if (top_ff.lo != top_ff.hi) begin
               if (top_ff.ph == PH_LEFT) begin
                  push      = 1'b1;
                  sp_in     = sp_ff + 1'b1;
                  top_in.hi = mid;
                  top_in.ph = PH_LEFT;
               end else if (top_ff.ph == PH_RIGHT) begin
                  push      = 1'b1;
                  sp_in     = sp_ff + 1'b1;
                  top_in.lo = mid1;
                  top_in.ph = PH_LEFT;
               end
            end
         end
         S_RET: begin
            if (sp_ff == '0) begin
               top_in.na = st.k;
            end else begin
               sp_in  = sp_ff - 1'b1;
               top_in = parent;
               if (parent.ph == PH_LEFT) begin
                  top_in.na = st.k;
                  top_in.ph = PH_RIGHT;
               end else begin
                  top_in.ph = PH_MERGE;
                  nb_in     = st.k;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         sp_ff    <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         count_ff <= count_in;
      end
      top_ff <= top_in;
      nb_ff  <= nb_in;
      if (push) stk_ff[sp_ff[STK_AW-1:0]] <= top_ff;
   end
endmodule

### src/skyline_merge_engine_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake      beat
// req_in    in   valid/ready    left_edge, right_edge, height, last_building
// rsp_out   out  valid/ready    point_x, point_height, last_point
//
// loading takes one cycle a building; the beat with last_building starts the build
// each leaf passes S_EVAL, S_LRD, S_LW0, S_LW1, S_RET; a merge passes S_EVAL, S_MINIT, then
// S_MRD and S_MEX in turn while points remain (registered buffer reads), then S_RET
// output repeats S_ORD, S_OLOAD, S_OWAIT (waits on rsp_out); no new beat is taken meanwhile
// synchronous reset returns to loading with an empty building store
module skyline_merge_engine_top import smg_pkg::*; (
   input logic       clock,
   input logic       reset,
   smg_req_if.sink   req_in,
   smg_rsp_if.source rsp_out
);
   cmd_type    cmd;
   status_type st;

   smg_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_in.valid),
      .req_last(req_in.last_building), .req_ready(req_in.ready),
      .rsp_valid(rsp_out.valid), .rsp_ready(rsp_out.ready), .st(st), .cmd(cmd)
   );

   smg_datapath u_dp (
      .clock(clock), .cmd(cmd), .in_left(req_in.left_edge), .in_right(req_in.right_edge),
      .in_height(req_in.height), .st(st), .out_x(rsp_out.point_x),
      .out_h(rsp_out.point_height), .out_last(rsp_out.last_point)
   );
endmodule

### src/smg_checker.sv
`timescale 1ns / 1ps
module smg_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("loading while emitting points");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("output did not end after last point");

   a_last_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_last))
      else $error("last flag changed while stalled");
endmodule

bind skyline_merge_engine_top smg_checker u_smg_checker (
   .clock(clock), .reset(reset), .req_valid(req_in.valid), .req_ready(req_in.ready),
   .rsp_valid(rsp_out.valid), .rsp_ready(rsp_out.ready), .rsp_last(rsp_out.last_point)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import smg_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [HGT_W-1:0]   h;
      logic               last;
   } point_type;

   typedef struct {
      logic [COORD_W-1:0] l;
      logic [COORD_W-1:0] r;
      logic [HGT_W-1:0]   h;
      logic               last;
      bit                 typed;
      point_type          p0;
      point_type          p1;
   } row_type;

   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   cycles = 0;

   smg_req_if req_bus ();
   smg_rsp_if rsp_bus ();

   skyline_merge_engine_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus.sink),
      .rsp_out (rsp_bus.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // building store mirror and expected key points
   logic [COORD_W-1:0] st_left [MAX_B];
   logic [COORD_W-1:0] st_right[MAX_B];
   logic [HGT_W-1:0]   st_hgt  [MAX_B];
   int                 st_count = 0;
   point_type          point_q[$];

   // divide and conquer skyline with explicit frame and list stacks
   task automatic compute_skyline();
      int                 f_lo[8], f_hi[8], f_ph[8];
      int                 fsp, lsp, lo, hi, mid, i, j, k, na, nb;
      logic [COORD_W-1:0] lx[8][PTS];
      logic [HGT_W-1:0]   lh[8][PTS];
      int                 ln[8];
      logic [COORD_W-1:0] tx[PTS];
      logic [HGT_W-1:0]   th[PTS];
      logic [HGT_W-1:0]   hl, hr, cur, m;
      point_type          p;
      fsp = 1; lsp = 0;
      f_lo[0] = 0; f_hi[0] = st_count - 1; f_ph[0] = 0;
      while (fsp > 0) begin
         lo = f_lo[fsp-1]; hi = f_hi[fsp-1];
         if (lo == hi) begin
            lx[lsp][0] = st_left[lo];  lh[lsp][0] = st_hgt[lo];
            lx[lsp][1] = st_right[lo]; lh[lsp][1] = '0;
            ln[lsp] = 2; lsp++; fsp--;
         end else if (f_ph[fsp-1] < 2) begin
            mid = (lo + hi) / 2;
            f_ph[fsp-1]++;
            if (f_ph[fsp-1] == 1) begin
               f_lo[fsp] = lo; f_hi[fsp] = mid;
            end else begin
               f_lo[fsp] = mid + 1; f_hi[fsp] = hi;
            end
            f_ph[fsp] = 0; fsp++;
         end else begin
            na = ln[lsp-2]; nb = ln[lsp-1];
            i = 0; j = 0; k = 0; hl = '0; hr = '0; cur = '0;
            while (i < na && j < nb) begin
               if (lx[lsp-2][i] < lx[lsp-1][j]) begin
                  hl = lh[lsp-2][i]; tx[k] = lx[lsp-2][i]; i++;
               end else if (lx[lsp-1][j] < lx[lsp-2][i]) begin
                  hr = lh[lsp-1][j]; tx[k] = lx[lsp-1][j]; j++;
               end else begin
                  hl = lh[lsp-2][i]; hr = lh[lsp-1][j]; tx[k] = lx[lsp-2][i]; i++; j++;
               end
               m = (hl > hr) ? hl : hr;
               if (m != cur && k < PTS) begin
                  th[k] = m; cur = m; k++;
               end
            end
            while (i < na && k < PTS) begin
               tx[k] = lx[lsp-2][i]; th[k] = lh[lsp-2][i]; i++; k++;
            end
            while (j < nb && k < PTS) begin
               tx[k] = lx[lsp-1][j]; th[k] = lh[lsp-1][j]; j++; k++;
            end
            lsp -= 2;
            for (i = 0; i < k; i++) begin
               lx[lsp][i] = tx[i]; lh[lsp][i] = th[i];
            end
            ln[lsp] = k; lsp++; fsp--;
         end
      end
      for (i = 0; i < ln[0]; i++) begin
         p.x = lx[0][i]; p.h = lh[0][i]; p.last = (i == ln[0] - 1);
         point_q.push_back(p);
      end
   endtask

   task automatic accept_building(row_type b);
      if (st_count < MAX_B) begin
         st_left[st_count] = b.l; st_right[st_count] = b.r; st_hgt[st_count] = b.h;
         st_count++;
      end
      if (b.last) begin
         if (b.typed) begin
            point_q.push_back(b.p0);
            point_q.push_back(b.p1);
         end else begin
            compute_skyline();
         end
         st_count = 0;
      end
   endtask

   // keeps valid high across a burst; lowered only in gaps
   task automatic send_building(row_type b);
      req_bus.valid         <= 1'b1;
      req_bus.left_edge     <= b.l;
      req_bus.right_edge    <= b.r;
      req_bus.height        <= b.h;
      req_bus.last_building <= b.last;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      accept_building(b);
   endtask

   int burst_left = 0;
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic row_type mk(int l, int r, int h, bit last);
      row_type b;
      b.l = COORD_W'(l); b.r = COORD_W'(r); b.h = HGT_W'(h); b.last = last; b.typed = 0;
      b.p0 = '0; b.p1 = '0;
      return b;
   endfunction

   function automatic row_type mk_single(int l, int r, int h);
      row_type b;
      b = mk(l, r, h, 1);
      b.typed = 1;
      b.p0 = '{x: COORD_W'(l), h: HGT_W'(h), last: 1'b0};
      b.p1 = '{x: COORD_W'(r), h: '0, last: 1'b1};
      return b;
   endfunction

   // receiver: stall pattern is redrawn at random from four modes
   int stall_mode = 0;
   always @(posedge clock) begin
      point_type want;
      cycles <= cycles + 1;
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= (cycles % 3 != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (point_q.size() == 0) begin
            $display("%0t: unexpected point x=%0d h=%0d last=%0b", $time,
                     rsp_bus.point_x, rsp_bus.point_height, rsp_bus.last_point);
            errors++;
         end else begin
            want = point_q.pop_front();
            if (want.x !== rsp_bus.point_x || want.h !== rsp_bus.point_height ||
                want.last !== rsp_bus.last_point) begin
               $display({"%0t: point mismatch expected x=%0d h=%0d last=%0b",
                         " actual x=%0d h=%0d last=%0b"},
                        $time, want.x, want.h, want.last,
                        rsp_bus.point_x, rsp_bus.point_height, rsp_bus.last_point);
               errors++;
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   row_type dir_rows[$];
   initial begin
      int sent, n, span, i;
      row_type b;
      req_bus.valid = 1'b0;
      req_bus.left_edge = '0;
      req_bus.right_edge = '0;
      req_bus.height = '0;
      req_bus.last_building = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows = '{
         mk_single(0, 65535, 65535),
         mk_single(5, 9, 0),
         mk_single(100, 50, 7),
         mk(1, 10, 5, 0), mk(3, 7, 9, 1),
         mk(2, 6, 4, 0), mk(2, 6, 8, 0), mk(6, 9, 3, 1),
         mk(20, 10, 5, 0), mk(0, 30, 2, 0), mk(15, 15, 65535, 1),
         mk(65535, 0, 43690, 0), mk(21845, 43690, 21845, 1),
         mk(0, 0, 0, 0), mk(65535, 65535, 65535, 1)
      };
      foreach (dir_rows[r]) begin
         pace();
         send_building(dir_rows[r]);
      end

      sent = 0;
      while (sent < 80) begin
         // mostly small sets; a few overfill the store
         if ($urandom_range(0, 15) == 0) n = $urandom_range(30, 35);
         else n = $urandom_range(1, 8);
         span = ($urandom_range(0, 2) == 0) ? 65535 : 31;
         for (i = 0; i < n; i++) begin
            b = mk($urandom_range(0, span), $urandom_range(0, span),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535), i == n - 1);
            if ($urandom_range(0, 3) != 0 && b.r < b.l) begin
               b.l = b.r; b.r = COORD_W'(b.l + $urandom_range(1, 40));
            end
            pace();
            send_building(b);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;
      while (point_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
